### rtl/crf_pkg.sv
// Shared types, constants and helpers for the cell range reference formatter.
// Holds the range and result item structs, controller commands and status, and the
// state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

	// Sheet limits
	localparam logic [31:0] MAX_ROWS = 32'd1048576;
	localparam logic [31:0] MAX_COLS = 32'd16384;

	// Narrow widths of a validated coordinate
	localparam int ROW_W  = 21;
	localparam int COL_W  = 15;
	localparam int WORK_W = ROW_W;

	// Longest digit string: seven decimal row digits
	localparam int STACK_DEPTH = 7;
	localparam int CNT_W       = 3;

	// Reciprocal multipliers: exact quotient for every valid coordinate
	localparam int                  MUL_W       = 20;
	localparam int                  PROD_W      = WORK_W + MUL_W;
	localparam logic [MUL_W-1:0]    DIV26_MUL   = 20'd20165;    // ceil(2^19 / 26)
	localparam logic [MUL_W-1:0]    DIV10_MUL   = 20'd838861;   // ceil(2^23 / 10)

	// Status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO     = 2'd1;
	localparam logic [1:0] STATUS_LIMIT    = 2'd2;
	localparam logic [1:0] STATUS_REVERSED = 2'd3;

	// ASCII codes
	localparam logic [6:0] CHAR_NUL   = 7'h00;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_COLON = 7'h3A;
	localparam logic [6:0] CHAR_A     = 7'h41;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;

	typedef struct packed {
		logic [31:0] top_row;
		logic [31:0] first_col;
		logic [31:0] bottom_row;
		logic [31:0] last_col;
		logic        lead_space;
	} crf_in_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
		logic [1:0] status;
	} crf_out_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_ERROR,
		EMIT_SPACE,
		EMIT_COLON,
		EMIT_POP
	} crf_emit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ERROR,
		ST_SPACE,
		ST_LOAD,
		ST_CONV,
		ST_EMIT,
		ST_COLON
	} crf_state_t;

	// Controller to datapath
	typedef struct packed {
		logic      capture;   // register a new range item
		logic      load;      // load the selected coordinate into the work register
		logic      step;      // one divide step, push one character
		crf_emit_t emit;      // kind of result item to issue
		logic      last;      // mark the issued item as final
		logic      sel_cell;  // 0 first cell, 1 last cell
		logic      sel_row;   // 0 column, 1 row
	} crf_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] status;     // check outcome of the captured range
		logic       single;     // both cells equal
		logic       lead_space;
		logic       conv_done;  // quotient of the current step is zero
		logic       stack_one;  // one character left to issue
	} crf_sts_t;

	// Validate one cell
	function automatic logic [1:0] check_cell(input logic [31:0] row, input logic [31:0] col);
		logic [1:0] res;
		if (row == 32'd0 || col == 32'd0) begin
			res = STATUS_ZERO;
		end else if (row > MAX_ROWS || col > MAX_COLS) begin
			res = STATUS_LIMIT;
		end else begin
			res = STATUS_OK;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/crf_datapath.sv
// Datapath of the cell range reference formatter: range register, checks,
// shared divide-by-26/10 unit, character stack and result register. Uses crf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crf_datapath (
	input  wire               clk,
	input  wire               arst_n,
	input  crf_pkg::crf_in_t  range_item,
	input  crf_pkg::crf_cmd_t cmd,
	output crf_pkg::crf_sts_t sts,
	output crf_pkg::crf_out_t result,
	output logic              strobe
);
	import crf_pkg::*;

	crf_in_t              item_q;
	logic [WORK_W-1:0]    work_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [6:0]           stack_q [STACK_DEPTH];
	crf_out_t             result_q;
	logic                 strobe_q;

	logic [1:0]           st_first;
	logic [1:0]           st_last;
	logic [1:0]           st_all;
	logic [WORK_W-1:0]    load_val;
	logic [WORK_W-1:0]    dividend;
	logic [MUL_W-1:0]     mul;
	logic [PROD_W-1:0]    prod;
	logic [WORK_W-1:0]    quot;
	logic [WORK_W-1:0]    quot_x_div;
	logic [WORK_W-1:0]    rem_full;
	logic [6:0]           digit_char;
	logic [CNT_W-1:0]     top_idx;

	// Check the range: first cell, last cell, then orientation
	always_comb begin
		st_first = check_cell(item_q.top_row, item_q.first_col);
		st_last  = check_cell(item_q.bottom_row, item_q.last_col);
		if (st_first != STATUS_OK) begin
			st_all = st_first;
		end else if (st_last != STATUS_OK) begin
			st_all = st_last;
		end else if (item_q.top_row > item_q.bottom_row ||
				item_q.first_col > item_q.last_col) begin
			st_all = STATUS_REVERSED;
		end else begin
			st_all = STATUS_OK;
		end
	end

	// Select the coordinate to convert
	always_comb begin
		unique case ({cmd.sel_cell, cmd.sel_row})
			2'b00:   load_val = {{(WORK_W-COL_W){1'b0}}, item_q.first_col[COL_W-1:0]};
			2'b01:   load_val = item_q.top_row[ROW_W-1:0];
			2'b10:   load_val = {{(WORK_W-COL_W){1'b0}}, item_q.last_col[COL_W-1:0]};
			default: load_val = item_q.bottom_row[ROW_W-1:0];
		endcase
	end

	// One divide step: columns are bijective (subtract one first), rows plain decimal
	always_comb begin
		dividend = cmd.sel_row ? work_q : (work_q - {{(WORK_W-1){1'b0}}, 1'b1});
		mul      = cmd.sel_row ? DIV10_MUL : DIV26_MUL;
		prod     = {{MUL_W{1'b0}}, dividend} * {{WORK_W{1'b0}}, mul};
		if (cmd.sel_row) begin
			quot       = {3'b000, prod[PROD_W-1:23]};
			quot_x_div = (quot << 3) + (quot << 1);
		end else begin
			quot       = {{(WORK_W-COL_W){1'b0}}, prod[33:19]};
			quot_x_div = (quot << 4) + (quot << 3) + (quot << 1);
		end
		rem_full   = dividend - quot_x_div;
		digit_char = (cmd.sel_row ? CHAR_ZERO : CHAR_A) + {2'b00, rem_full[4:0]};
	end

	assign top_idx = cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};

	// Capture the item, advance the work value and push each converted character
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= range_item;
		end
		if (cmd.load) begin
			work_q <= load_val;
		end else if (cmd.step) begin
			work_q <= quot;
		end
		if (cmd.step) begin
			stack_q[cnt_q] <= digit_char;
		end
	end

	// Stack fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.capture) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
		end else if (cmd.emit == EMIT_POP) begin
			cnt_q <= top_idx;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			EMIT_ERROR: result_q <= '{out_char: CHAR_NUL, last_char: 1'b1, status: st_all};
			EMIT_SPACE: result_q <= '{out_char: CHAR_SPACE, last_char: 1'b0,
				status: STATUS_OK};
			EMIT_COLON: result_q <= '{out_char: CHAR_COLON, last_char: 1'b0,
				status: STATUS_OK};
			EMIT_POP:   result_q <= '{out_char: stack_q[top_idx], last_char: cmd.last,
				status: STATUS_OK};
			default:    result_q <= result_q;
		endcase
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.emit != EMIT_NONE);
		end
	end

	assign sts.status     = st_all;
	assign sts.single     = (item_q.top_row == item_q.bottom_row) &&
		(item_q.first_col == item_q.last_col);
	assign sts.lead_space = item_q.lead_space;
	assign sts.conv_done  = (quot == '0);
	assign sts.stack_one  = (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1});

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

`default_nettype wire

### rtl/crf_controller.sv
// Controller of the cell range reference formatter: sequences check, conversion
// and issue of each field. Uses crf_pkg; drives crf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module crf_controller (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  crf_pkg::crf_sts_t sts,
	output crf_pkg::crf_cmd_t cmd,
	output logic              busy
);
	import crf_pkg::*;

	crf_state_t state_q;
	crf_state_t state_d;
	logic       cell_q;
	logic       cell_d;
	logic       row_q;
	logic       row_d;

	// Next state and field selection
	always_comb begin
		state_d = state_q;
		cell_d  = cell_q;
		row_d   = row_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cell_d = 1'b0;
				row_d  = 1'b0;
				if (sts.status != STATUS_OK) begin
					state_d = ST_ERROR;
				end else if (sts.lead_space) begin
					state_d = ST_SPACE;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_ERROR: state_d = ST_IDLE;
			ST_SPACE: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_CONV;
			ST_CONV: begin
				if (sts.conv_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.stack_one) begin
					if (!row_q) begin
						row_d   = 1'b1;
						state_d = ST_LOAD;
					end else if (cell_q || sts.single) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_COLON;
					end
				end
			end
			ST_COLON: begin
				cell_d  = 1'b1;
				row_d   = 1'b0;
				state_d = ST_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.emit     = EMIT_NONE;
		cmd.sel_cell = cell_q;
		cmd.sel_row  = row_q;
		unique case (state_q)
			ST_IDLE:  cmd.capture = start;
			ST_CHECK: cmd.capture = 1'b0;
			ST_ERROR: cmd.emit = EMIT_ERROR;
			ST_SPACE: cmd.emit = EMIT_SPACE;
			ST_LOAD:  cmd.load = 1'b1;
			ST_CONV:  cmd.step = 1'b1;
			ST_EMIT: begin
				cmd.emit = EMIT_POP;
				cmd.last = sts.stack_one && row_q && (cell_q || sts.single);
			end
			ST_COLON: cmd.emit = EMIT_COLON;
			default:  cmd.emit = EMIT_NONE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cell_q  <= 1'b0;
			row_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cell_q  <= cell_d;
			row_q   <= row_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/cell_range_reference_formatter_unit.sv
// Top level of the cell range reference formatter: controller plus datapath.
// Depends on crf_pkg, crf_controller and crf_datapath.
//
//   channel   ports                      handshake
//   range     start, busy, range_item    taken at a rising edge with start high, busy low
//   result    strobe, result             one cycle per item, strobe high; no back-pressure
//
// An error range gives one item. A good range gives an optional leading space, the first
// cell, and for a range of more than one cell a colon and the last cell: each field is
// loaded, divided by 26 or 10 one character a cycle on the shared reciprocal unit into a
// stack, then issued one character a cycle. Each item appears in the result register in
// the cycle after it is issued. Reset clears the controller, the stack count and the output
// strobe only. Results cannot be held off, so nothing stalls once an item is taken.
`timescale 1ns / 1ps
`default_nettype none

module cell_range_reference_formatter_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  crf_pkg::crf_in_t  range_item,
	output logic              strobe,
	output crf_pkg::crf_out_t result
);
	import crf_pkg::*;

	crf_cmd_t cmd;
	crf_sts_t sts;

	// Sequencer
	crf_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Checks, conversion and result register
	crf_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.range_item (range_item),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result),
		.strobe     (strobe)
	);

endmodule

`default_nettype wire

### sim/crf_stream_checker.sv
// Checker for the cell range reference formatter: predicts the character stream of each
// accepted range and compares every result item against it. Depends on crf_pkg only.
`timescale 1ns / 1ps

module crf_stream_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  crf_pkg::crf_in_t  range_item,
	input  wire               strobe,
	input  crf_pkg::crf_out_t result,
	output int                fails,
	output int                pending,
	output int                n_ranges,
	output int                n_rejected,
	output int                n_chars
);
	import crf_pkg::*;

	localparam int PRINT_CAP = 100;

	crf_out_t   expected_chars[$];
	logic [6:0] spelled[$];
	int         fail_count = 0;
	int         range_count = 0;
	int         reject_count = 0;
	int         char_count = 0;

	// Print one line per mismatch (up to a cap) and count it
	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (fail_count < PRINT_CAP)
			$display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h (result item %0d)",
				$time, what, got, want, char_count);
		fail_count++;
	endtask

	// Status of one cell: zero first, then sheet limits
	function automatic logic [1:0] cell_status(input logic [31:0] row, input logic [31:0] col);
		if (row == 32'd0 || col == 32'd0)
			return STATUS_ZERO;
		if (row > MAX_ROWS || col > MAX_COLS)
			return STATUS_LIMIT;
		return STATUS_OK;
	endfunction

	// Append a column in bijective base-26 letters
	function automatic void spell_column(input logic [31:0] col);
		logic [6:0] letters[8];
		int         cnt;
		cnt = 0;
		while (col != 32'd0 && cnt < 8) begin
			col = col - 32'd1;
			letters[cnt] = CHAR_A + 7'(col % 32'd26);
			cnt++;
			col = col / 32'd26;
		end
		while (cnt > 0) begin
			cnt--;
			spelled.insert(spelled.size(), letters[cnt]);
		end
	endfunction

	// Append a row in decimal
	function automatic void spell_row(input logic [31:0] row);
		logic [6:0] digits[10];
		int         cnt;
		cnt = 0;
		do begin
			digits[cnt] = CHAR_ZERO + 7'(row % 32'd10);
			cnt++;
			row = row / 32'd10;
		end while (row != 32'd0 && cnt < 10);
		while (cnt > 0) begin
			cnt--;
			spelled.insert(spelled.size(), digits[cnt]);
		end
	endfunction

	// Work out the result items of one range and queue them
	task automatic spell_range(input crf_in_t r);
		logic [1:0] st;
		crf_out_t   item;
		st = cell_status(r.top_row, r.first_col);
		if (st == STATUS_OK)
			st = cell_status(r.bottom_row, r.last_col);
		if (st == STATUS_OK && (r.top_row > r.bottom_row || r.first_col > r.last_col))
			st = STATUS_REVERSED;
		range_count++;
		if (st != STATUS_OK) begin
			item.out_char  = CHAR_NUL;
			item.last_char = 1'b1;
			item.status    = st;
			expected_chars.insert(expected_chars.size(), item);
			reject_count++;
		end else begin
			spelled.delete();
			if (r.lead_space)
				spelled.insert(spelled.size(), CHAR_SPACE);
			spell_column(r.first_col);
			spell_row(r.top_row);
			if (r.top_row != r.bottom_row || r.first_col != r.last_col) begin
				spelled.insert(spelled.size(), CHAR_COLON);
				spell_column(r.last_col);
				spell_row(r.bottom_row);
			end
			foreach (spelled[i]) begin
				item.out_char  = spelled[i];
				item.last_char = (i == spelled.size() - 1);
				item.status    = STATUS_OK;
				expected_chars.insert(expected_chars.size(), item);
			end
		end
	endtask

	// Compare one result item with the oldest expectation
	task automatic check_char(input crf_out_t got);
		crf_out_t want;
		if (expected_chars.size() == 0) begin
			report_mismatch("result item with nothing expected", 32'(got), 0);
		end else begin
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char)
				report_mismatch("out_char", 32'(got.out_char), 32'(want.out_char));
			if (got.last_char !== want.last_char)
				report_mismatch("last_char", 32'(got.last_char), 32'(want.last_char));
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
		end
		char_count++;
	endtask

	// Watch both channels at each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				check_char(result);
			if (start && !busy)
				spell_range(range_item);
		end
		fails      <= fail_count;
		pending    <= expected_chars.size();
		n_ranges   <= range_count;
		n_rejected <= reject_count;
		n_chars    <= char_count;
	end

endmodule

### sim/tb_cell_range_reference_formatter_unit.sv
// Testbench top for cell_range_reference_formatter_unit: drives directed and random ranges
// with random gaps and gives the verdict. Depends on crf_pkg and crf_stream_checker.
`timescale 1ns / 1ps

module tb_cell_range_reference_formatter_unit;
	import crf_pkg::*;

	localparam int RANDOM_ITEMS = 236;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 60;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     strobe;
	crf_in_t  range_item;
	crf_out_t result;

	int fails;
	int pending;
	int n_ranges;
	int n_rejected;
	int n_chars;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	cell_range_reference_formatter_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.range_item (range_item),
		.strobe     (strobe),
		.result     (result)
	);

	crf_stream_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.range_item (range_item),
		.strobe     (strobe),
		.result     (result),
		.fails      (fails),
		.pending    (pending),
		.n_ranges   (n_ranges),
		.n_rejected (n_rejected),
		.n_chars    (n_chars)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("** cell_range_reference_formatter_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Idle for a random gap, then hold start until the item is taken
	task automatic send_range(input logic [31:0] r0, input logic [31:0] c0,
			input logic [31:0] r1, input logic [31:0] c1, input logic sp);
		crf_in_t item;
		int      gap;
		item.top_row    = r0;
		item.first_col  = c0;
		item.bottom_row = r1;
		item.last_col   = c1;
		item.lead_space = sp;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		range_item <= item;
		do @(posedge clk); while (busy);
	endtask

	// Valid row, weighted towards digit-count boundaries and small values
	function automatic logic [31:0] pick_row();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(1, 12);
			1: begin
				case ($urandom_range(0, 7))
					0: v = 32'd9;
					1: v = 32'd10;
					2: v = 32'd99;
					3: v = 32'd100;
					4: v = 32'd999999;
					5: v = 32'd1000000;
					6: v = MAX_ROWS - 32'd1;
					default: v = MAX_ROWS;
				endcase
			end
			default: v = $urandom_range(1, MAX_ROWS);
		endcase
		return v;
	endfunction

	// Valid column, weighted towards letter-count boundaries
	function automatic logic [31:0] pick_col();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(1, 30);
			1: begin
				case ($urandom_range(0, 7))
					0: v = 32'd26;
					1: v = 32'd27;
					2: v = 32'd52;
					3: v = 32'd676;
					4: v = 32'd702;
					5: v = 32'd703;
					6: v = MAX_COLS - 32'd1;
					default: v = MAX_COLS;
				endcase
			end
			default: v = $urandom_range(1, MAX_COLS);
		endcase
		return v;
	endfunction

	// Well-formed range with random content, sometimes one cell or one row or column
	task automatic send_good_range();
		logic [31:0] r0, c0, r1, c1, tmp;
		r0 = pick_row();
		r1 = pick_row();
		c0 = pick_col();
		c1 = pick_col();
		if (r0 > r1) begin
			tmp = r0;
			r0  = r1;
			r1  = tmp;
		end
		if (c0 > c1) begin
			tmp = c0;
			c0  = c1;
			c1  = tmp;
		end
		case ($urandom_range(0, 4))
			0: begin
				r1 = r0;
				c1 = c0;
			end
			1: r1 = r0;
			2: c1 = c0;
			default: ;
		endcase
		send_range(r0, c0, r1, c1, 1'($urandom_range(0, 1)));
	endtask

	// Broken or noisy range: raw words, zeros, over limits, reversed, flipped bits
	task automatic send_broken_range();
		logic [31:0] f[4];
		int          k;
		int          j;
		f[0] = pick_row();
		f[1] = pick_col();
		f[2] = pick_row();
		f[3] = pick_col();
		k = $urandom_range(0, 3);
		case ($urandom_range(0, 5))
			0: for (j = 0; j < 4; j++) f[j] = $urandom();
			1: f[k] = 32'd0;
			2: begin
				if ($urandom_range(0, 1))
					f[k] = 32'hFFFF_FFFF;
				else if (k % 2 == 0)
					f[k] = MAX_ROWS + 32'd1 + $urandom_range(0, 1000);
				else
					f[k] = MAX_COLS + 32'd1 + $urandom_range(0, 1000);
			end
			3: begin
				f[2] = $urandom_range(1, MAX_ROWS - 1);
				f[0] = $urandom_range(f[2] + 1, MAX_ROWS);
			end
			4: begin
				f[3] = $urandom_range(1, MAX_COLS - 1);
				f[1] = $urandom_range(f[3] + 1, MAX_COLS);
			end
			default: f[k] = f[k] ^ (32'd1 << $urandom_range(0, 31));
		endcase
		send_range(f[0], f[1], f[2], f[3], 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		range_item = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single cells, longest reference, letter and digit rollovers
		send_range(32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
		send_range(32'd1, 32'd1, 32'd1, 32'd1, 1'b1);
		send_range(MAX_ROWS, MAX_COLS, MAX_ROWS, MAX_COLS, 1'b0);
		send_range(32'd1, 32'd1, MAX_ROWS, MAX_COLS, 1'b1);
		send_range(32'd9, 32'd26, 32'd10, 32'd27, 1'b0);
		send_range(32'd99, 32'd52, 32'd100, 32'd53, 1'b1);
		send_range(32'd999999, 32'd702, 32'd1000000, 32'd703, 1'b0);
		send_range(32'd5, 32'd676, 32'd5, 32'd677, 1'b0);
		send_range(32'd1, 32'd1, 32'd1, 32'd2, 1'b0);
		// Zero coordinates in each position; no space on an error
		send_range(32'd0, 32'd1, 32'd1, 32'd1, 1'b1);
		send_range(32'd1, 32'd0, 32'd1, 32'd1, 1'b0);
		send_range(32'd1, 32'd1, 32'd0, 32'd1, 1'b0);
		send_range(32'd1, 32'd1, 32'd1, 32'd0, 1'b1);
		// Over the sheet limits in each position
		send_range(MAX_ROWS + 32'd1, 32'd1, MAX_ROWS + 32'd1, 32'd1, 1'b0);
		send_range(32'd1, MAX_COLS + 32'd1, 32'd1, MAX_COLS + 32'd1, 1'b0);
		send_range(32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 1'b0);
		send_range(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 1'b1);
		// Check order: first cell before last, zero before limit within a cell
		send_range(32'd0, 32'd5, 32'hFFFF_FFFF, 32'd5, 1'b0);
		send_range(32'd2000000, 32'd1, 32'd0, 32'd1, 1'b0);
		send_range(32'd0, 32'd20000, 32'd1, 32'd1, 1'b1);
		// Reversed ranges, then one over the limits in every position
		send_range(32'd10, 32'd1, 32'd9, 32'd1, 1'b0);
		send_range(32'd1, 32'd27, 32'd1, 32'd26, 1'b1);
		send_range(MAX_ROWS, MAX_COLS, 32'd1, 32'd1, 1'b0);
		send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

		// Random: mostly well-formed ranges, the rest broken or noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) < 7)
				send_good_range();
			else
				send_broken_range();
		end
		start <= 1'b0;

		// Drain, then allow for stray items
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d ranges, %0d of them rejected with an error status,", n_ranges,
			n_rejected);
		$display("and checked %0d result items, with gapped and back-to-back stretches.",
			n_chars);
		if (pending != 0)
			$display("%0d expected result items never arrived", pending);
		if (fails == 0 && pending == 0) begin
			$display("** cell_range_reference_formatter_unit: PASSED **");
		end else begin
			$display("** cell_range_reference_formatter_unit: FAILED **");
		end
		$finish;
	end

endmodule
